// ===== src/ctmf_pkg.sv =====
// ----------------------------------------------------------------------------
// ctmf_pkg
// Shared types, codes and sizes of the complex template matched filter.
// ----------------------------------------------------------------------------
package ctmf_pkg;

   localparam int WINDOW_DEPTH_DEF = 8192;
   localparam int SAMPLE_BITS_DEF  = 16;

   localparam int WSIZE_BITS = 14;
   localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = 14'd8192;

   localparam int ENERGY_BITS = 46;
   localparam int CORR_BITS   = 47;
   localparam int SNR_BITS    = 32;
   localparam int SCALE_SHIFT = 16;

   // root of energy * 2^16, dividend |corr| * 2^16
   localparam int ROOT_BITS = (ENERGY_BITS + SCALE_SHIFT) / 2;
   localparam int DIVD_BITS = CORR_BITS + SCALE_SHIFT;
   localparam int REM_BITS  = ROOT_BITS + 1;
   localparam int STEP_BITS = ROOT_BITS + 3;
   localparam int ITER_BITS = $clog2(DIVD_BITS);

   typedef enum logic {
      OP_TEMPLATE = 1'b0,
      OP_DATA     = 1'b1
   } ctmf_op_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_NO_TEMPLATE = 2'd1,
      STATUS_ZERO_ENERGY = 2'd2
   } ctmf_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_ACC,
      ST_NORM,
      ST_EMIT
   } ctmf_state_type;

   typedef enum logic [1:0] {
      NS_IDLE,
      NS_ROOT,
      NS_DIV,
      NS_DONE
   } ctmf_norm_state_type;

   typedef struct packed {
      logic                   start;
      logic [ENERGY_BITS-1:0] energy;
      logic [CORR_BITS-1:0]   corr;
   } ctmf_norm_req_type;

   typedef struct packed {
      logic                done;
      logic [SNR_BITS-1:0] snr;
   } ctmf_norm_rsp_type;

endpackage

// ===== src/ctmf_if.sv =====
// ----------------------------------------------------------------------------
// ctmf_if
// Valid/ready channels of the matched filter: sample words in, results out.
// ----------------------------------------------------------------------------
interface ctmf_req_if import ctmf_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   ctmf_op_type                   op;
   logic signed [SAMPLE_BITS-1:0] sample_real;
   logic signed [SAMPLE_BITS-1:0] sample_imag;

   modport source (output valid, op, sample_real, sample_imag, input ready);
   modport sink (input valid, op, sample_real, sample_imag, output ready);
endinterface

interface ctmf_rsp_if import ctmf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SNR_BITS-1:0] snr;
   ctmf_status_type            status;

   modport source (output valid, snr, status, input ready);
   modport sink (input valid, snr, status, output ready);
endinterface

// ===== src/complex_template_matched_filter.sv =====
// ----------------------------------------------------------------------------
// complex_template_matched_filter
// Normalized complex correlation of data windows against a stored template.
// ----------------------------------------------------------------------------
// Each sample word goes through accept, two products through the one shared
// multiplier and a final accumulate; req_ch.ready is high only between words.
// The last word of a data window whose template is valid with nonzero energy
// also runs 31 square-root steps and 63 divide steps through one 34-bit
// compare/subtract unit, then the result goes to the output register. A result
// that is still waiting there stalls only the next window's last word. The
// template store has no reset; entries are defined once written.
module complex_template_matched_filter import ctmf_pkg::*; #(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [WSIZE_BITS-1:0] csr_wr_data,
   ctmf_req_if.sink              req_ch,
   ctmf_rsp_if.source            rsp_ch
);

   localparam int POS_BITS  = $clog2(WINDOW_DEPTH);
   localparam int PROD_BITS = 2 * SAMPLE_BITS;
   localparam int EXT_BITS  = 64;

   ctmf_state_type         state_ff, state_in;
   logic [WSIZE_BITS-1:0]  wsize_ff, wsize_in;
   logic [POS_BITS-1:0]    tpos_ff, tpos_in;
   logic [POS_BITS-1:0]    dpos_ff, dpos_in;
   logic [ENERGY_BITS-1:0] energy_acc_ff, energy_acc_in;
   logic [ENERGY_BITS-1:0] tenergy_ff, tenergy_in;
   logic [CORR_BITS-1:0]   corr_acc_ff, corr_acc_in;
   logic                   tvalid_ff, tvalid_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   ctmf_op_type                   op_ff, op_in;
   logic signed [SAMPLE_BITS-1:0] re_ff, re_in;
   logic signed [SAMPLE_BITS-1:0] im_ff, im_in;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   ctmf_status_type               status_pend_ff, status_pend_in;
   logic [SNR_BITS-1:0]           rsp_snr_ff, rsp_snr_in;
   ctmf_status_type               rsp_status_ff, rsp_status_in;

   logic                          accept;
   logic                          out_free;
   logic                          rsp_load;
   logic                          norm_go;
   logic                          is_last;
   logic [31:0]                   win_m1;
   logic [POS_BITS-1:0]           last_idx;
   logic [POS_BITS-1:0]           pos_cur;
   logic                          ram_wr_en, ram_rd_en;
   logic [PROD_BITS-1:0]          ram_rd_data;
   logic signed [SAMPLE_BITS-1:0] rd_re, rd_im;
   logic signed [SAMPLE_BITS-1:0] mul_a, mul_b;
   logic signed [PROD_BITS-1:0]   mul_p;
   logic [EXT_BITS-1:0]           prod_ext;
   logic [ENERGY_BITS-1:0]        energy_sum;
   logic [CORR_BITS-1:0]          corr_sum;
   ctmf_norm_req_type             norm_req;
   ctmf_norm_rsp_type             norm_rsp;

   ctmf_ram #(
      .WIDTH (PROD_BITS),
      .DEPTH (WINDOW_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tpos_ff),
      .wr_data ({req_ch.sample_real, req_ch.sample_imag}),
      .rd_en   (ram_rd_en),
      .rd_addr (dpos_ff),
      .rd_data (ram_rd_data)
   );

   ctmf_norm_div u_norm (
      .clock    (clock),
      .reset    (reset),
      .norm_req (norm_req),
      .norm_rsp (norm_rsp)
   );

   // window bounds
   always_comb begin
      if (wsize_ff == '0) begin
         win_m1 = '0;
      end else if (32'(wsize_ff) > 32'(WINDOW_DEPTH)) begin
         win_m1 = 32'(WINDOW_DEPTH - 1);
      end else begin
         win_m1 = 32'(wsize_ff) - 32'd1;
      end
   end
   assign last_idx = win_m1[POS_BITS-1:0];
   assign pos_cur  = (op_ff == OP_TEMPLATE) ? tpos_ff : dpos_ff;
   assign is_last  = pos_cur == last_idx;
   assign norm_go  = tvalid_ff && (tenergy_ff != '0);

   // shared multiplier
   assign rd_re = ram_rd_data[PROD_BITS-1:SAMPLE_BITS];
   assign rd_im = ram_rd_data[SAMPLE_BITS-1:0];
   always_comb begin
      mul_a = (state_ff == ST_MUL_A) ? re_ff : im_ff;
      if (op_ff == OP_TEMPLATE) begin
         mul_b = mul_a;
      end else begin
         mul_b = (state_ff == ST_MUL_A) ? rd_re : rd_im;
      end
      mul_p = mul_a * mul_b;
   end

   assign prod_ext   = {{(EXT_BITS-PROD_BITS){prod_ff[PROD_BITS-1]}}, prod_ff};
   assign energy_sum = energy_acc_ff + prod_ext[ENERGY_BITS-1:0];
   assign corr_sum   = corr_acc_ff + prod_ext[CORR_BITS-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A: state_in = ST_MUL_B;
         ST_MUL_B: state_in = ST_ACC;
         ST_ACC: begin
            if (op_ff == OP_DATA && is_last) begin
               state_in = norm_go ? ST_NORM : ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_NORM: begin
            if (norm_rsp.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ch.ready    = (state_ff == ST_IDLE) && !reset;
      accept          = req_ch.valid && (state_ff == ST_IDLE) && !reset;
      ram_wr_en       = accept && (req_ch.op == OP_TEMPLATE);
      ram_rd_en       = accept && (req_ch.op == OP_DATA);
      out_free        = !rsp_valid_ff || rsp_ch.ready;
      rsp_load        = (state_ff == ST_EMIT) && out_free;
      norm_req.start  = (state_ff == ST_ACC) && (op_ff == OP_DATA) && is_last && norm_go;
      norm_req.energy = tenergy_ff;
      norm_req.corr   = corr_sum;
   end

   // datapath next values
   always_comb begin
      wsize_in       = wsize_ff;
      tpos_in        = tpos_ff;
      dpos_in        = dpos_ff;
      energy_acc_in  = energy_acc_ff;
      tenergy_in     = tenergy_ff;
      corr_acc_in    = corr_acc_ff;
      tvalid_in      = tvalid_ff;
      rsp_valid_in   = rsp_valid_ff;
      op_in          = op_ff;
      re_in          = re_ff;
      im_in          = im_ff;
      prod_in        = prod_ff;
      status_pend_in = status_pend_ff;
      rsp_snr_in     = rsp_snr_ff;
      rsp_status_in  = rsp_status_ff;

      if (accept) begin
         op_in = req_ch.op;
         re_in = req_ch.sample_real;
         im_in = req_ch.sample_imag;
         if (req_ch.op == OP_TEMPLATE && tpos_ff == '0) begin
            tvalid_in = 1'b0;
         end
      end

      if (state_ff == ST_MUL_A || state_ff == ST_MUL_B) begin
         prod_in = mul_p;
      end

      if (state_ff == ST_MUL_B || state_ff == ST_ACC) begin
         if (op_ff == OP_TEMPLATE) begin
            energy_acc_in = energy_sum;
         end else begin
            corr_acc_in = corr_sum;
         end
      end

      if (state_ff == ST_ACC) begin
         if (op_ff == OP_TEMPLATE) begin
            if (is_last) begin
               tenergy_in    = energy_sum;
               tvalid_in     = 1'b1;
               energy_acc_in = '0;
               tpos_in       = '0;
            end else begin
               tpos_in = tpos_ff + 1'b1;
            end
         end else begin
            if (is_last) begin
               dpos_in     = '0;
               corr_acc_in = '0;
               if (!tvalid_ff) begin
                  status_pend_in = STATUS_NO_TEMPLATE;
               end else if (tenergy_ff == '0) begin
                  status_pend_in = STATUS_ZERO_ENERGY;
               end else begin
                  status_pend_in = STATUS_OK;
               end
            end else begin
               dpos_in = dpos_ff + 1'b1;
            end
         end
      end

      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_snr_in    = (status_pend_ff == STATUS_OK) ? norm_rsp.snr : '0;
         rsp_status_in = status_pend_ff;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         wsize_in      = csr_wr_data;
         tpos_in       = '0;
         dpos_in       = '0;
         energy_acc_in = '0;
         corr_acc_in   = '0;
         tvalid_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wsize_ff      <= WSIZE_RESET;
         tpos_ff       <= '0;
         dpos_ff       <= '0;
         energy_acc_ff <= '0;
         tenergy_ff    <= '0;
         corr_acc_ff   <= '0;
         tvalid_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wsize_ff      <= wsize_in;
         tpos_ff       <= tpos_in;
         dpos_ff       <= dpos_in;
         energy_acc_ff <= energy_acc_in;
         tenergy_ff    <= tenergy_in;
         corr_acc_ff   <= corr_acc_in;
         tvalid_ff     <= tvalid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      re_ff          <= re_in;
      im_ff          <= im_in;
      prod_ff        <= prod_in;
      status_pend_ff <= status_pend_in;
      rsp_snr_ff     <= rsp_snr_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.snr    = rsp_snr_ff;
   assign rsp_ch.status = rsp_status_ff;

   // checks
   a_pos_in_window: assert property (@(posedge clock) disable iff (reset)
      (tpos_ff <= last_idx) && (dpos_ff <= last_idx))
      else $error("window position beyond window");

   a_valid_from_acc: assert property (@(posedge clock) disable iff (reset)
      $rose(tvalid_ff) |-> $past(state_ff) == ST_ACC)
      else $error("template marked valid outside window completion");

   a_norm_done_wait: assert property (@(posedge clock) disable iff (reset)
      norm_rsp.done |-> state_ff == ST_NORM)
      else $error("normalizer finished while sequencer not waiting");

   a_status_snr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STATUS_OK) |-> rsp_snr_ff == '0)
      else $error("nonzero snr with error status");

endmodule

// ===== src/ctmf_ram.sv =====
// ----------------------------------------------------------------------------
// ctmf_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ctmf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ctmf_norm_div.sv =====
// ----------------------------------------------------------------------------
// ctmf_norm_div
// Iterative normalizer: square root of the template energy, then division of
// the correlation by that root, sharing one compare/subtract unit.
// ----------------------------------------------------------------------------
module ctmf_norm_div import ctmf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  ctmf_norm_req_type norm_req,
   output ctmf_norm_rsp_type norm_rsp
);

   ctmf_norm_state_type nstate_ff, nstate_in;
   logic [ITER_BITS-1:0] iter_ff, iter_in;
   logic [DIVD_BITS-1:0] work_ff, work_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [ROOT_BITS-1:0] root_ff, root_in;
   logic [CORR_BITS-1:0] mag_ff, mag_in;
   logic                 neg_ff, neg_in;

   logic [STEP_BITS-1:0] step_a, step_b, step_diff;
   logic                 step_ge;
   logic [CORR_BITS-1:0] corr_mag;

   // shared compare/subtract
   always_comb begin
      if (nstate_ff == NS_ROOT) begin
         step_a = {rem_ff, work_ff[DIVD_BITS-1 -: 2]};
         step_b = {1'b0, root_ff, 2'b01};
      end else begin
         step_a = {1'b0, rem_ff, work_ff[DIVD_BITS-1]};
         step_b = {3'b000, root_ff};
      end
      step_ge   = step_a >= step_b;
      step_diff = step_a - step_b;
   end

   assign corr_mag = norm_req.corr[CORR_BITS-1] ? (~norm_req.corr + 1'b1) : norm_req.corr;

   always_comb begin
      nstate_in = nstate_ff;
      case (nstate_ff)
         NS_IDLE: begin
            if (norm_req.start) begin
               nstate_in = NS_ROOT;
            end
         end
         NS_ROOT: begin
            if (iter_ff == '0) begin
               nstate_in = NS_DIV;
            end
         end
         NS_DIV: begin
            if (iter_ff == '0) begin
               nstate_in = NS_DONE;
            end
         end
         NS_DONE: nstate_in = NS_IDLE;
         default: nstate_in = NS_IDLE;
      endcase
   end

   always_comb begin
      iter_in = iter_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      case (nstate_ff)
         NS_IDLE: begin
            if (norm_req.start) begin
               work_in = {norm_req.energy, {(DIVD_BITS - ENERGY_BITS){1'b0}}};
               rem_in  = '0;
               root_in = '0;
               iter_in = ITER_BITS'(ROOT_BITS - 1);
               mag_in  = corr_mag;
               neg_in  = norm_req.corr[CORR_BITS-1];
            end
         end
         NS_ROOT: begin
            root_in = {root_ff[ROOT_BITS-2:0], step_ge};
            rem_in  = step_ge ? step_diff[REM_BITS-1:0] : step_a[REM_BITS-1:0];
            work_in = {work_ff[DIVD_BITS-3:0], 2'b00};
            iter_in = iter_ff - 1'b1;
            if (iter_ff == '0) begin
               work_in = {mag_ff, {SCALE_SHIFT{1'b0}}};
               rem_in  = '0;
               iter_in = ITER_BITS'(DIVD_BITS - 1);
            end
         end
         NS_DIV: begin
            rem_in  = step_ge ? step_diff[REM_BITS-1:0] : step_a[REM_BITS-1:0];
            work_in = {work_ff[DIVD_BITS-2:0], step_ge};
            iter_in = iter_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nstate_ff <= NS_IDLE;
      end else begin
         nstate_ff <= nstate_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
   end

   // quotient sits in work_ff; saturate to signed 32 bits
   always_comb begin
      norm_rsp.done = nstate_ff == NS_DONE;
      if (!neg_ff) begin
         if (|work_ff[DIVD_BITS-1:SNR_BITS-1]) begin
            norm_rsp.snr = {1'b0, {(SNR_BITS-1){1'b1}}};
         end else begin
            norm_rsp.snr = work_ff[SNR_BITS-1:0];
         end
      end else begin
         if (|work_ff[DIVD_BITS-1:SNR_BITS] ||
             (work_ff[SNR_BITS-1] && |work_ff[SNR_BITS-2:0])) begin
            norm_rsp.snr = {1'b1, {(SNR_BITS-1){1'b0}}};
         end else begin
            norm_rsp.snr = ~work_ff[SNR_BITS-1:0] + 1'b1;
         end
      end
   end

endmodule
